// ----- src/omni3_pkg.sv -----
// Shared types, constants and tables for the three-wheel omni odometry unit.
// No dependencies; imported by omni3_cordic, omni_three_wheel_odometry_unit and the testbench.
package omni3_pkg;

  // Default sizing for the top-level parameters
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int POS_WIDTH_DEF   = 48;
  localparam int TRIG_WIDTH_DEF  = 16;

  // Configuration port
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN  = 1'b1;
  localparam logic [CFG_W-1:0] TICK_LENGTH_RST = 24'd2019343;
  localparam logic [CFG_W-1:0] ANGLE_GAIN_RST  = 24'd392430;

  // Stream payload layout
  localparam int IN_FIELD_W  = 32;
  localparam int POS_OUT_W   = 48;
  localparam int OUT_FIELD_W = 32;
  localparam int S_DATA_W    = 3 * IN_FIELD_W;
  localparam int M_DATA_W    = 2 * POS_OUT_W + 4 * OUT_FIELD_W;

  // Kinematic scale factors, Q18
  localparam logic [17:0] SQRT3_3_Q18 = 18'd151349;
  localparam logic [17:0] THIRD_Q18   = 18'd87381;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 30;
  localparam int CORD_W       = 34;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

  // atan(2^-i) as a binary angle, full turn 2^32
  function automatic logic [31:0] cordic_atan(input logic [ITER_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      5'd24:   r = 32'd41;
      5'd25:   r = 32'd20;
      5'd26:   r = 32'd10;
      5'd27:   r = 32'd5;
      5'd28:   r = 32'd3;
      5'd29:   r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/omni3_cordic.sv -----
// Iterative CORDIC: sine and cosine of a binary angle, one rotation per cycle.
// Depends on omni3_pkg (atan table, gain, datapath width).
module omni3_cordic
  import omni3_pkg::*;
#(
  parameter int TRIG_WIDTH = TRIG_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [31:0]                  angle,
  output logic                         done,
  output logic signed [TRIG_WIDTH-1:0] sin_q,
  output logic signed [TRIG_WIDTH-1:0] cos_q
);

  localparam int SH = 32 - TRIG_WIDTH;
  localparam logic signed [CORD_W-1:0] RND = CORD_W'(1) <<< (SH - 1);

  typedef enum logic [1:0] {C_IDLE, C_ITER, C_ROUND} cstate_t;

  cstate_t                   state;
  logic [ITER_W-1:0]         iter;
  logic                      flip;
  logic signed [CORD_W-1:0]  x;
  logic signed [CORD_W-1:0]  y;
  logic signed [CORD_W-1:0]  z;
  logic                      fold;
  logic [31:0]               ang_fold;
  logic signed [CORD_W-1:0]  atan_i;
  logic signed [CORD_W-1:0]  xf;
  logic signed [CORD_W-1:0]  yf;

  // Fold into [-pi/2, pi/2) by adding pi; results are negated at the end
  always_comb begin
    ang_fold = angle + 32'h4000_0000;
    fold     = ang_fold[31];
    ang_fold = fold ? (angle + 32'h8000_0000) : angle;
  end

  assign atan_i = $signed(CORD_W'(cordic_atan(iter)));
  assign xf     = flip ? -x : x;
  assign yf     = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      iter  <= '0;
    end else begin
      case (state)
        C_IDLE: begin
          if (start) begin
            x     <= $signed(CORD_W'(CORDIC_GAIN_Q30));
            y     <= '0;
            z     <= CORD_W'($signed(ang_fold));
            flip  <= fold;
            iter  <= '0;
            done  <= 1'b0;
            state <= C_ITER;
          end
        end
        C_ITER: begin
          // Rotate toward zero residual angle
          if (!z[CORD_W-1]) begin
            x <= x - (y >>> iter);
            y <= y + (x >>> iter);
            z <= z - atan_i;
          end else begin
            x <= x + (y >>> iter);
            y <= y - (x >>> iter);
            z <= z + atan_i;
          end
          if (iter == ITER_W'(CORDIC_STEPS - 1)) begin
            state <= C_ROUND;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        C_ROUND: begin
          // Undo fold, round half up to Q(TRIG_WIDTH-2)
          cos_q <= TRIG_WIDTH'((xf + RND) >>> SH);
          sin_q <= TRIG_WIDTH'((yf + RND) >>> SH);
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// ----- src/omni_three_wheel_odometry_unit.sv -----
// Three-wheel omni odometry: encoder deltas, kinematics, rotation, pose integration.
// Depends on omni3_pkg and omni3_cordic.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------------
//  s_*     | in  | s_tvalid/s_tready | count_a, count_b, count_c
//  m_*     | out | m_tvalid/m_tready | pos_x, pos_y, heading, step_x/y/heading
//  cfg_*   | in  | cfg_wen           | tick_length (0), angle_gain (1)
//
// The 30-step CORDIC of the old heading sets the time from acceptance to result, while
// five of the nine products on the shared multiplier run alongside it. Reset is
// synchronous and clears pose, last counts and loads the register defaults. A finished
// result waits in the output register; a new request is taken meanwhile, never earlier,
// and its result holds until the old one is taken.
module omni_three_wheel_odometry_unit
  import omni3_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int POS_WIDTH   = POS_WIDTH_DEF,
  parameter int TRIG_WIDTH  = TRIG_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // count_a, count_b, count_c
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // pos_x, pos_y, heading, step_x, step_y,
                                          // step_heading
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CW  = COUNT_WIDTH;
  localparam int MA  = CW + 12;           // widest kinematic operand
  localparam int MB  = CFG_W + 1;         // register, scale or trig operand
  localparam int PW  = MA + MB;
  localparam int ACC_W = 64;

  typedef enum logic [1:0] {S_IDLE, S_BUSY, S_FINISH} state_t;
  typedef enum logic [3:0] {
    OP_HEAD, OP_PT, OP_QT, OP_U, OP_V, OP_CU, OP_SV, OP_SU, OP_CV
  } op_t;

  state_t                   state;
  op_t                      step;
  op_t                      prod_tag;
  logic                     issuing;
  logic                     prod_vld;
  logic [CFG_W-1:0]         tick_length;
  logic [CFG_W-1:0]         angle_gain;
  logic [CW-1:0]            last_a;
  logic [CW-1:0]            last_b;
  logic [CW-1:0]            last_c;
  logic [POS_WIDTH-1:0]     pose_x;
  logic [POS_WIDTH-1:0]     pose_y;
  logic [31:0]              pose_heading;
  logic signed [CW-1:0]     da;
  logic signed [CW-1:0]     db;
  logic signed [CW-1:0]     dc;
  logic signed [MA-1:0]     u_pre;
  logic signed [MA-1:0]     v_pre;
  logic signed [MA-1:0]     u;
  logic signed [MA-1:0]     v;
  logic signed [PW-1:0]     prod;
  logic signed [ACC_W-1:0]  prod64;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  dx;
  logic signed [ACC_W-1:0]  dy;
  logic [31:0]              dh;
  logic signed [ACC_W-1:0]  dx_sh;
  logic signed [ACC_W-1:0]  dy_sh;
  logic [POS_WIDTH-1:0]     pose_x_next;
  logic [POS_WIDTH-1:0]     pose_y_next;
  logic [31:0]              heading_next;
  logic signed [CW+1:0]     sum3;
  logic signed [CW:0]       p;
  logic signed [CW+1:0]     q;
  logic signed [MA-1:0]     mul_a;
  logic signed [MB-1:0]     mul_b;
  logic                     issue_ok;
  logic                     accept;
  logic                     out_free;
  logic                     trig_done;
  logic signed [TRIG_WIDTH-1:0] trig_sin;
  logic signed [TRIG_WIDTH-1:0] trig_cos;

  // Saturate a 64-bit step to 32 bits
  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] val);
    logic [31:0] r;
    if ((&val[ACC_W-1:31]) || !(|val[ACC_W-1:31])) begin
      r = val[31:0];
    end else begin
      r = val[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Sine and cosine of the heading held before this sample
  omni3_cordic #(
    .TRIG_WIDTH(TRIG_WIDTH)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .angle (pose_heading),
    .done  (trig_done),
    .sin_q (trig_sin),
    .cos_q (trig_cos)
  );

  // Tick combinations
  assign sum3 = (CW+2)'(da) + (CW+2)'(db) + (CW+2)'(dc);
  assign p    = (CW+1)'(da) - (CW+1)'(db);
  assign q    = (CW+2)'(dc) + (CW+2)'(dc) - (CW+2)'(da) - (CW+2)'(db);

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      OP_HEAD: begin mul_a = MA'(sum3);  mul_b = $signed({1'b0, angle_gain}); end
      OP_PT:   begin mul_a = MA'(p);     mul_b = $signed({1'b0, tick_length}); end
      OP_QT:   begin mul_a = MA'(q);     mul_b = $signed({1'b0, tick_length}); end
      OP_U:    begin mul_a = u_pre;      mul_b = $signed(MB'(SQRT3_3_Q18)); end
      OP_V:    begin mul_a = v_pre;      mul_b = $signed(MB'(THIRD_Q18)); end
      OP_CU:   begin mul_a = u;          mul_b = MB'(trig_cos); end
      OP_SV:   begin mul_a = v;          mul_b = MB'(trig_sin); end
      OP_SU:   begin mul_a = u;          mul_b = MB'(trig_sin); end
      OP_CV:   begin mul_a = v;          mul_b = MB'(trig_cos); end
      default: begin mul_a = '0;         mul_b = '0; end
    endcase
  end

  // Rotation waits for the CORDIC
  assign issue_ok = issuing && !(step == OP_CU && !trig_done);
  assign prod64   = ACC_W'(prod);

  // Final pose update
  assign dx_sh        = dx >>> (TRIG_WIDTH - 2);
  assign dy_sh        = dy >>> (TRIG_WIDTH - 2);
  assign pose_x_next  = pose_x + dx_sh[POS_WIDTH-1:0];
  assign pose_y_next  = pose_y + dy_sh[POS_WIDTH-1:0];
  assign heading_next = pose_heading + dh;

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= OP_HEAD;
      issuing      <= 1'b0;
      prod_vld     <= 1'b0;
      m_tvalid     <= 1'b0;
      tick_length  <= TICK_LENGTH_RST;
      angle_gain   <= ANGLE_GAIN_RST;
      last_a       <= '0;
      last_b       <= '0;
      last_c       <= '0;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_TICK_LENGTH: tick_length <= cfg_wdata;
          REG_ANGLE_GAIN:  angle_gain  <= cfg_wdata;
          default: ;
        endcase
      end

      // Output register empties on a handshake unless the finish step refills it
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            da      <= s_tdata[CW-1:0] - last_a;
            db      <= s_tdata[IN_FIELD_W +: CW] - last_b;
            dc      <= s_tdata[2*IN_FIELD_W +: CW] - last_c;
            last_a  <= s_tdata[CW-1:0];
            last_b  <= s_tdata[IN_FIELD_W +: CW];
            last_c  <= s_tdata[2*IN_FIELD_W +: CW];
            step    <= OP_HEAD;
            issuing <= 1'b1;
            state   <= S_BUSY;
          end
        end
        S_BUSY: begin
          // Issue one product a cycle, holding at the first rotation product until the CORDIC is done
          if (issue_ok) begin
            prod     <= PW'(mul_a) * PW'(mul_b);
            prod_tag <= step;
            prod_vld <= 1'b1;
            if (step == OP_CV) begin
              issuing <= 1'b0;
            end else begin
              step <= op_t'(step + 1);
            end
          end else begin
            prod_vld <= 1'b0;
          end
          // Write back the product issued last cycle
          if (prod_vld) begin
            case (prod_tag)
              OP_HEAD: dh    <= prod[39:8];
              OP_PT:   u_pre <= MA'(prod >>> 16);
              OP_QT:   v_pre <= MA'(prod >>> 16);
              OP_U:    u     <= MA'(prod >>> 18);
              OP_V:    v     <= MA'(prod >>> 18);
              OP_CU:   acc   <= prod64;
              OP_SV:   dx    <= acc - prod64;
              OP_SU:   acc   <= prod64;
              OP_CV:   dy    <= acc + prod64;
              default: ;
            endcase
            if (prod_tag == OP_CV) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          prod_vld <= 1'b0;
          if (out_free) begin
            pose_x       <= pose_x_next;
            pose_y       <= pose_y_next;
            pose_heading <= heading_next;
            m_tdata      <= {dh, sat32(dy_sh), sat32(dx_sh), heading_next,
                             POS_OUT_W'(pose_y_next), POS_OUT_W'(pose_x_next)};
            m_tvalid     <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result appears only out of the finish step
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FINISH))
    else $error("result raised outside finish step");

  // Rotation products wait for the CORDIC
  a_trig_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_BUSY && issuing && step == OP_CU && !trig_done) |=> !prod_vld)
    else $error("rotation issued before sine and cosine were ready");

  // The last product closes the sequence
  a_last_product: assert property (@(posedge clk) disable iff (rst)
    (state == S_BUSY && prod_vld && prod_tag == OP_CV) |=> (state == S_FINISH))
    else $error("sequence did not reach finish after last product");

  // No request is taken while a sample is in flight
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_BUSY) |-> !s_tready)
    else $error("request accepted while busy");
`endif

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for omni_three_wheel_odometry_unit: encoder count requests in,
// pose reports out, each checked against an in-bench model of the odometry arithmetic.
// Depends on omni3_pkg and the unit under test; drives random idling and output stalls.
module testbench;
  import omni3_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_CYCLES = 40;
  localparam int TRIG_SHIFT   = 32 - TRIG_WIDTH_DEF;
  localparam int TRIG_FRAC    = TRIG_WIDTH_DEF - 2;
  localparam longint TRIG_HALF = 64'sd1 <<< (TRIG_SHIFT - 1);
  localparam longint KIN_ROOT3 = 64'sd151349;  // sqrt(3)/3, Q18
  localparam longint KIN_THIRD = 64'sd87381;   // 1/3, Q18
  localparam longint LIM32     = 64'sd2147483647;

  typedef struct packed {
    logic [47:0] pos_x;
    logic [47:0] pos_y;
    logic [31:0] heading;
    logic [31:0] step_x;
    logic [31:0] step_y;
    logic [31:0] step_heading;
  } pose_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;   // count_a, count_b, count_c
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;        // pos_x, pos_y, heading, step_x, step_y,
                                        // step_heading
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // atan(2^-i) as binary angle, full turn 2^32
  longint atan_steps [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1
  };

  // Tracked copy of the unit's registers and state
  logic [23:0] tick_len;
  logic [23:0] ang_gain;
  logic [31:0] last_a, last_b, last_c;
  logic [47:0] pose_x, pose_y;
  logic [31:0] pose_h;

  // Counts last offered, used to build plausible motion
  logic [31:0] cur_a = '0, cur_b = '0, cur_c = '0;

  pose_report_t pending_poses [$];
  pose_report_t want, got;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  rx_wait = 0;
  int  rx_hold = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;

  omni_three_wheel_odometry_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic void clear_tracker();
    tick_len = 24'd2019343;
    ang_gain = 24'd392430;
    last_a = '0;
    last_b = '0;
    last_c = '0;
    pose_x = '0;
    pose_y = '0;
    pose_h = '0;
  endfunction

  function automatic longint count_step(input logic [31:0] now, input logic [31:0] prev);
    logic [31:0] diff;
    diff = now - prev;
    return longint'($signed(diff));
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > LIM32) return 32'h7FFF_FFFF;
    if (v < -LIM32 - 1) return 32'h8000_0000;
    return 32'(v);
  endfunction

  // Sine and cosine of a binary angle by CORDIC, folded to the right half plane
  function automatic void heading_trig(input logic [31:0] ang, output longint sin_q,
                                       output longint cos_q);
    logic [31:0] probe, folded;
    logic flip;
    longint x, y, z, xn, yn;
    int i;
    probe = ang + 32'h4000_0000;
    flip = probe[31];
    folded = flip ? ang + 32'h8000_0000 : ang;
    x = 64'sd652032874;
    y = 64'sd0;
    z = longint'($signed(folded));
    for (i = 0; i < 30; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        yn = y + (x >>> i);
        z = z - atan_steps[i];
      end else begin
        xn = x + (y >>> i);
        yn = y - (x >>> i);
        z = z + atan_steps[i];
      end
      x = xn;
      y = yn;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_q = (x + TRIG_HALF) >>> TRIG_SHIFT;
    sin_q = (y + TRIG_HALF) >>> TRIG_SHIFT;
  endfunction

  // Wheel deltas -> heading change and world-frame step, then integrate
  function automatic pose_report_t advance_pose(input logic [31:0] ca, input logic [31:0] cb,
                                                input logic [31:0] cc);
    pose_report_t r;
    longint da, db, dc, p, q, u, v, sn, cs, dx, dy, tl;
    logic [31:0] old_h, dh;
    da = count_step(ca, last_a);
    db = count_step(cb, last_b);
    dc = count_step(cc, last_c);
    last_a = ca;
    last_b = cb;
    last_c = cc;
    old_h = pose_h;
    dh = 32'(((da + db + dc) * longint'(ang_gain)) >>> 8);
    tl = longint'(tick_len);
    p = da - db;
    q = dc + dc - da - db;
    u = (((p * tl) >>> 16) * KIN_ROOT3) >>> 18;
    v = (((q * tl) >>> 16) * KIN_THIRD) >>> 18;
    heading_trig(old_h, sn, cs);
    dx = (cs * u - sn * v) >>> TRIG_FRAC;
    dy = (sn * u + cs * v) >>> TRIG_FRAC;
    pose_x = pose_x + 48'(dx);
    pose_y = pose_y + 48'(dy);
    pose_h = old_h + dh;
    r.pos_x = pose_x;
    r.pos_y = pose_y;
    r.heading = pose_h;
    r.step_x = clamp32(dx);
    r.step_y = clamp32(dy);
    r.step_heading = dh;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Send one request; idle cycles before it mostly count while the unit is ready
  task automatic offer_counts(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    while (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      if (s_tready || $urandom_range(0, 1)) gap--;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {c, b, a};
    do @(posedge clk); while (!s_tready);
    pending_poses.push_back(advance_pose(a, b, c));
    cur_a = a;
    cur_b = b;
    cur_c = c;
  endtask

  function automatic logic [31:0] next_count(input logic [31:0] prev, input int mode,
                                             input logic [31:0] spin);
    logic [31:0] d;
    int width;
    width = $urandom_range(0, 16);
    d = $urandom & ((32'd1 << width) - 32'd1);
    if ($urandom_range(0, 1)) d = -d;
    case (mode)
      6, 7:    return prev + spin + (d >> 8);        // mostly turning in place
      8:       return $urandom;                      // arbitrary jump
      9:       return prev + ($urandom | 32'h4000_0000);  // huge delta
      default: return prev + d;                      // ordinary driving
    endcase
  endfunction

  task automatic offer_random_move();
    int mode;
    logic [31:0] spin;
    mode = $urandom_range(0, 9);
    spin = $urandom_range(0, 24'hFF_FFFF);
    if ($urandom_range(0, 1)) spin = -spin;
    offer_counts(next_count(cur_a, mode, spin), next_count(cur_b, mode, spin),
                 next_count(cur_c, mode, spin));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_TICK_LENGTH: tick_len = val;
      REG_ANGLE_GAIN:  ang_gain = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Stop offering, wait for every pose report, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- output side

  // Receiver: long hold-off first, then per-report stalls counted mostly
  // against a waiting report
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      if (m_tvalid || $urandom_range(0, 1)) rx_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [47:0] exp_v,
                             input logic [47:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  // Checker: compare each accepted report with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.pos_x        = m_tdata[47:0];
      got.pos_y        = m_tdata[95:48];
      got.heading      = m_tdata[127:96];
      got.step_x       = m_tdata[159:128];
      got.step_y       = m_tdata[191:160];
      got.step_heading = m_tdata[223:192];
      if (pending_poses.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected report, expected none, got %h", $time, m_tdata);
      end else begin
        want = pending_poses.pop_front();
        check_field("pos_x", want.pos_x, got.pos_x);
        check_field("pos_y", want.pos_y, got.pos_y);
        check_field("heading", want.heading, got.heading);
        check_field("step_x", want.step_x, got.step_x);
        check_field("step_y", want.step_y, got.step_y);
        check_field("step_heading", want.step_heading, got.step_heading);
      end
      rx_wait = rx_idle ? $urandom_range(0, 12) : 0;
    end
  end

  // ---------------------------------------------------------------- tests

  // Unit gain puts the heading exactly on each quadrant boundary before a
  // translation; the first request also runs against zero last counts
  task automatic test_heading_quadrants();
    int k;
    write_reg(REG_ANGLE_GAIN, 24'd256);
    for (k = 0; k < 4; k++) begin
      offer_counts(cur_a + 32'h4000_0000, cur_b, cur_c);
      offer_counts(cur_a + 32'd700, cur_b - 32'd400, cur_c - 32'd300);
    end
  endtask

  // Field extremes and standing still
  task automatic test_count_extremes();
    offer_counts(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    offer_counts(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    offer_counts(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
  endtask

  // Encoder counters wrapping in both directions give small deltas
  task automatic test_counter_wrap();
    offer_counts(32'h7FFF_FFF0, 32'hFFFF_FFF0, 32'h0000_0010);
    offer_counts(32'h8000_0010, 32'h0000_0010, 32'hFFFF_FFF0);
    offer_counts(32'h8000_0030, 32'h0000_0005, 32'hFFFF_FFE0);
  endtask

  // Steps far beyond 32 bits: step outputs clamp, pose keeps the full change
  task automatic test_large_steps();
    drain_results();
    write_reg(REG_TICK_LENGTH, 24'hFF_FFFF);
    offer_counts(cur_a + 32'h7FFF_FFFF, cur_b + 32'h8000_0000, cur_c);
    offer_counts(cur_a + 32'h8000_0000, cur_b + 32'h7FFF_FFFF, cur_c);
    offer_counts(cur_a, cur_b, cur_c + 32'h7FFF_FFFF);
    offer_counts(cur_a, cur_b, cur_c + 32'h8000_0000);
  endtask

  task automatic test_random_motion(input int count, input logic [23:0] tl,
                                    input logic [23:0] ag, input bit idle);
    int n;
    drain_results();
    write_reg(REG_TICK_LENGTH, tl);
    write_reg(REG_ANGLE_GAIN, ag);
    for (n = 0; n < count; n++) begin
      // switch idling on and off in stretches
      if (n % 40 == 0) begin
        tx_idle = idle && ($urandom_range(0, 3) != 0);
        rx_idle = idle && ($urandom_range(0, 3) != 0);
      end
      offer_random_move();
    end
  endtask

  // Receiver holds off while requests keep coming, so the unit stalls its input
  task automatic test_output_stall();
    int n;
    drain_results();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 400;
    for (n = 0; n < 16; n++) offer_random_move();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d reports outstanding", $time,
             cycle_count, pending_poses.size());
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    clear_tracker();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_heading_quadrants();
    test_count_extremes();
    test_counter_wrap();
    test_large_steps();

    test_random_motion(350, 24'd2019343, 24'd392430, 1'b1);
    test_output_stall();
    test_random_motion(100, 24'd0, 24'd0, 1'b1);
    test_random_motion(250, 24'hFF_FFFF, 24'hFF_FFFF, 1'b0);
    test_random_motion(300, $urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 24'hFF_FFFF),
                       1'b1);
    test_random_motion(200, $urandom_range(1, 4096), $urandom_range(0, 24'hFF_FFFF), 1'b1);

    drain_results();
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/omni3_pkg.sv
src/omni3_cordic.sv
src/omni_three_wheel_odometry_unit.sv
sim/testbench.sv
